### rtl/shd_pkg.sv
`default_nettype none
package shd_pkg;

   localparam int YEAR_FIELD_BITS = 12;
   localparam int DAYS_BITS       = 21;
   localparam int DAYS_MAX        = 2097151;
   localparam int CYCLE_YEARS     = 33;
   localparam int MONTHS          = 12;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_FIRST_BAD    = 2'd1;
   localparam logic [1:0] STATUS_SECOND_BAD   = 2'd2;

   localparam logic [5:0] LEAP_RESIDUES [8] = '{
      6'd1, 6'd5, 6'd9, 6'd13, 6'd17, 6'd22, 6'd26, 6'd30
   };

   typedef struct packed {
      logic [4:0]                 first_day;
      logic [3:0]                 first_month;
      logic [YEAR_FIELD_BITS-1:0] first_year;
      logic [4:0]                 second_day;
      logic [3:0]                 second_month;
      logic [YEAR_FIELD_BITS-1:0] second_year;
   } shd_req_type;

   typedef struct packed {
      logic [DAYS_BITS-1:0] days_between;
      logic                 first_is_later;
      logic [1:0]           status;
   } shd_rsp_type;

   function automatic logic is_leap(input logic [5:0] r);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < 8; i++) begin
         hit = hit | (r == LEAP_RESIDUES[i]);
      end
      return hit;
   endfunction

   // leap years among cycle positions 0 .. r-1
   function automatic logic [3:0] leaps_below(input logic [5:0] r);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'd0, (LEAP_RESIDUES[i] < r)};
      end
      return n;
   endfunction

   // days before day 1 of month m
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] off;
      case (m)
         4'd1:    off = 9'd0;
         4'd2:    off = 9'd31;
         4'd3:    off = 9'd62;
         4'd4:    off = 9'd93;
         4'd5:    off = 9'd124;
         4'd6:    off = 9'd155;
         4'd7:    off = 9'd186;
         4'd8:    off = 9'd216;
         4'd9:    off = 9'd246;
         4'd10:   off = 9'd276;
         4'd11:   off = 9'd306;
         4'd12:   off = 9'd336;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

   function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
                                    input logic leap);
      logic [4:0] len;
      if (m >= 4'd1 && m <= 4'd6) begin
         len = 5'd31;
      end else if (m >= 4'd7 && m <= 4'd11) begin
         len = 5'd30;
      end else if (m == 4'(MONTHS)) begin
         len = leap ? 5'd30 : 5'd29;
      end else begin
         len = 5'd0;
      end
      return (d != 5'd0) && (d <= len);
   endfunction

endpackage
`default_nettype wire

### rtl/solar_hijri_day_difference.sv
`default_nettype none
// Solar Hijri day difference. A date pair is taken on any cycle where start is
// high and busy is low, one pair per cycle with no gaps. Each date becomes a day
// number (year / 33 by a constant reciprocal multiply, then 365*y plus leap count
// plus month offset plus day); the back end subtracts and checks. The result
// strobes on rsp_valid for one cycle, in order, after front stages a and b, the
// queue and the back-end register; the receiver cannot stall, so busy never
// rises in normal use. status flags an invalid first and/or second date, and
// then the other result fields are zero. Only the low YW bits of years are used.
module solar_hijri_day_difference
   import shd_pkg::*;
#(
   parameter int YEAR_BITS = 12
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire shd_req_type  req_data,
   output logic              rsp_valid,
   output shd_rsp_type       rsp_data
);

   localparam int YW       = (YEAR_BITS < YEAR_FIELD_BITS) ? YEAR_BITS : YEAR_FIELD_BITS;
   localparam int DAY_BITS = $clog2(366 * (1 << YW));
   localparam int ENTRY_W  = 2 * DAY_BITS + 2;

   logic               accept;
   logic               front_valid;
   logic [ENTRY_W-1:0] front_data;
   logic [ENTRY_W-1:0] queue_data;
   logic               queue_empty;
   logic               queue_full;
   logic               queue_pop;

   assign busy      = queue_full;
   assign accept    = start & ~busy;
   assign queue_pop = ~queue_empty;

   shd_front #(
      .YEAR_BITS (YEAR_BITS),
      .DAY_BITS  (DAY_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   shd_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_data),
      .pop       (queue_pop),
      .pop_data  (queue_data),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   shd_back #(
      .DAY_BITS (DAY_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (queue_pop),
      .in_data   (queue_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### rtl/shd_front.sv
`default_nettype none
module shd_front
   import shd_pkg::*;
#(
   parameter int YEAR_BITS = 12,
   parameter int DAY_BITS  = 22
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire shd_req_type               in_data,
   output logic                           out_valid,
   output logic [2*DAY_BITS+1:0]          out_data
);

   localparam int YW   = (YEAR_BITS < YEAR_FIELD_BITS) ? YEAR_BITS : YEAR_FIELD_BITS;
   localparam int K    = YW + 6;
   localparam int MULT = ((1 << K) + CYCLE_YEARS - 1) / CYCLE_YEARS;
   localparam int PW   = YW + K;
   localparam int QW   = YW - 5;

   logic [4:0]    day   [2];
   logic [3:0]    month [2];
   logic [YW-1:0] year  [2];

   logic            valid_a_ff, valid_a_in;
   logic            valid_b_ff, valid_b_in;
   logic [4:0]      day_a_ff   [2];
   logic [3:0]      month_a_ff [2];
   logic [YW-1:0]   year_a_ff  [2];
   logic [QW-1:0]   quot_a_ff  [2];
   logic [QW-1:0]   quot_a_in  [2];
   logic [DAY_BITS-1:0] num_b_ff [2];
   logic [DAY_BITS-1:0] num_b_in [2];
   logic            ok_b_ff [2];
   logic            ok_b_in [2];

   assign day[0]   = in_data.first_day;
   assign month[0] = in_data.first_month;
   assign year[0]  = in_data.first_year[YW-1:0];
   assign day[1]   = in_data.second_day;
   assign month[1] = in_data.second_month;
   assign year[1]  = in_data.second_year[YW-1:0];

   assign valid_a_in = in_valid;
   assign valid_b_in = valid_a_ff;

   for (genvar g = 0; g < 2; g++) begin : g_date
      logic [PW-1:0]   prod;
      logic [YW-1:0]   q33;
      logic [5:0]      rem;
      logic            leap;

      // year / 33 by reciprocal multiply, exact over the year range
      assign prod         = PW'(year[g]) * PW'(MULT);
      assign quot_a_in[g] = prod[K+QW-1:K];

      assign q33  = YW'(quot_a_ff[g]) * YW'(CYCLE_YEARS);
      assign rem  = 6'(year_a_ff[g] - q33);
      assign leap = is_leap(rem);

      assign ok_b_in[g]  = date_ok(day_a_ff[g], month_a_ff[g], leap);
      assign num_b_in[g] = DAY_BITS'(year_a_ff[g]) * DAY_BITS'(365)
                         + DAY_BITS'({quot_a_ff[g], 3'd0})
                         + DAY_BITS'(leaps_below(rem))
                         + DAY_BITS'(month_offset(month_a_ff[g]))
                         + DAY_BITS'(day_a_ff[g]) - DAY_BITS'(1);

      always_ff @(posedge clock) begin
         day_a_ff[g]   <= day[g];
         month_a_ff[g] <= month[g];
         year_a_ff[g]  <= year[g];
         quot_a_ff[g]  <= quot_a_in[g];
         num_b_ff[g]   <= num_b_in[g];
         ok_b_ff[g]    <= ok_b_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_data  = {ok_b_ff[1], ok_b_ff[0], num_b_ff[1], num_b_ff[0]};

endmodule
`default_nettype wire

### rtl/shd_queue.sv
`default_nettype none
module shd_queue
   import shd_pkg::*;
#(
   parameter int WIDTH = 46
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty,
   output logic                  full
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign empty   = (count_ff == 2'd0);
   assign full    = (count_ff == 2'd2);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   assign wr_ptr_in = wr_ptr_ff ^ do_push;
   assign rd_ptr_in = rd_ptr_ff ^ do_pop;
   assign count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

### rtl/shd_back.sv
`default_nettype none
module shd_back
   import shd_pkg::*;
#(
   parameter int DAY_BITS = 22
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [2*DAY_BITS+1:0]    in_data,
   output logic                          rsp_valid,
   output shd_rsp_type                   rsp_data
);

   localparam int WW = (DAY_BITS > DAYS_BITS) ? DAY_BITS : DAYS_BITS;

   logic [DAY_BITS-1:0] num1;
   logic [DAY_BITS-1:0] num2;
   logic                ok1;
   logic                ok2;
   logic                later;
   logic [DAY_BITS-1:0] diff;
   logic [WW-1:0]       diff_w;
   logic [1:0]          status;

   logic        valid_ff, valid_in;
   shd_rsp_type rsp_ff, rsp_in;

   assign num1 = in_data[DAY_BITS-1:0];
   assign num2 = in_data[2*DAY_BITS-1:DAY_BITS];
   assign ok1  = in_data[2*DAY_BITS];
   assign ok2  = in_data[2*DAY_BITS+1];

   assign later  = (num1 > num2);
   assign diff   = later ? (num1 - num2) : (num2 - num1);
   assign diff_w = WW'(diff);
   assign status = (ok1 ? STATUS_OK : STATUS_FIRST_BAD)
                 | (ok2 ? STATUS_OK : STATUS_SECOND_BAD);

   always_comb begin
      rsp_in = '0;
      rsp_in.status = status;
      if (status == STATUS_OK) begin
         rsp_in.first_is_later = later;
         if (diff_w > WW'(DAYS_MAX)) begin
            rsp_in.days_between = DAYS_BITS'(DAYS_MAX);
         end else begin
            rsp_in.days_between = diff_w[DAYS_BITS-1:0];
         end
      end
   end

   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
